// File: rtl/rfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfd_pkg: shared types and constants of the reply frame deframer
// Field widths, event and register codes, the frame phase machine encoding
// and the control structures passed between the front and back parts.
// ----------------------------------------------------------------------------
package rfd_pkg;

    // Fixed field widths
    localparam int BYTE_W     = 8;
    localparam int INDEX_W    = 9;
    localparam int LIMIT_W    = 10;
    localparam int EVENT_W    = 3;
    localparam int FLEN_W     = 16;
    localparam int COUNT_W    = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    // Default payload buffer depth
    localparam int DEF_BUFFER_DEPTH = 512;

    // Register reset values
    localparam logic [BYTE_W-1:0]  RST_WANTED_SEQUENCE = 8'd1;
    localparam logic [LIMIT_W-1:0] RST_LENGTH_LIMIT    = 10'd512;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PREAMBLE_FIRST  = 3'd0,
        CFG_PREAMBLE_SECOND = 3'd1,
        CFG_WANTED_OPCODE   = 3'd2,
        CFG_WANTED_SEQUENCE = 3'd3,
        CFG_LENGTH_LIMIT    = 3'd4,
        CFG_EMPTY_STATUS    = 3'd5
    } t_cfg_reg;

    // Result event codes
    typedef enum logic [EVENT_W-1:0] {
        EV_ABSORBED = 3'd0,
        EV_ACCEPTED = 3'd1,
        EV_BAD_SUM  = 3'd2,
        EV_NOT_OURS = 3'd3,
        EV_OVERSIZE = 3'd4,
        EV_READ     = 3'd5
    } t_event;

    // Operation of a queued item
    typedef enum logic {
        OP_RX   = 1'b0,
        OP_READ = 1'b1
    } t_op;

    // Frame phase machine, one-hot
    typedef enum logic [8:0] {
        PH_HUNT_A  = 9'b000000001,
        PH_HUNT_B  = 9'b000000010,
        PH_OPCODE  = 9'b000000100,
        PH_SEQ     = 9'b000001000,
        PH_LEN_LO  = 9'b000010000,
        PH_LEN_HI  = 9'b000100000,
        PH_PAYLOAD = 9'b001000000,
        PH_CHECK   = 9'b010000000,
        PH_SKIP    = 9'b100000000
    } t_phase;

    // Configuration register contents
    typedef struct packed {
        logic [BYTE_W-1:0]  preamble_first;
        logic [BYTE_W-1:0]  preamble_second;
        logic [BYTE_W-1:0]  wanted_opcode;
        logic [BYTE_W-1:0]  wanted_sequence;
        logic [LIMIT_W-1:0] length_limit;
        logic [BYTE_W-1:0]  empty_status;
    } t_cfg;

    // Classified item held in the queue between front and back
    typedef struct packed {
        t_op                op;
        logic [BYTE_W-1:0]  rx_byte;
        logic [INDEX_W-1:0] read_index;
        logic               hit_first;
        logic               hit_second;
    } t_entry;

endpackage

// File: rtl/rfd_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfd_ifs: valid/ready channels of the reply frame deframer
// Input item channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface rfd_in_if;
    import rfd_pkg::*;
    logic               valid;
    logic               ready;
    logic               kind;
    logic [BYTE_W-1:0]  rx_byte;
    logic [INDEX_W-1:0] read_index;
    modport source (output valid, kind, rx_byte, read_index, input ready);
    modport sink   (input valid, kind, rx_byte, read_index, output ready);
endinterface

interface rfd_out_if;
    import rfd_pkg::*;
    logic               valid;
    logic               ready;
    logic [EVENT_W-1:0] event_res;
    logic [BYTE_W-1:0]  reply_status;
    logic [LIMIT_W-1:0] reply_length;
    logic [BYTE_W-1:0]  read_data;
    modport source (output valid, event_res, reply_status, reply_length, read_data,
                    input ready);
    modport sink   (input valid, event_res, reply_status, reply_length, read_data,
                    output ready);
endinterface

interface rfd_cfg_if;
    import rfd_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/rfd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfd_front: item intake and classification
// Accepts input items, tags them as received bytes or buffer reads, matches
// received bytes against the preamble and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module rfd_front
    import rfd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg_regs,
    rfd_in_if.sink     i_in,
    output logic       o_q_valid,
    output t_entry     o_q_entry,
    input  logic       i_q_pop
);

    t_entry     r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       push;
    t_entry     in_entry;

    // Classify the incoming item.
    always_comb begin
        in_entry.op         = i_in.kind ? OP_READ : OP_RX;
        in_entry.rx_byte    = i_in.rx_byte;
        in_entry.read_index = i_in.read_index;
        in_entry.hit_first  = (i_in.rx_byte == i_cfg_regs.preamble_first);
        in_entry.hit_second = (i_in.rx_byte == i_cfg_regs.preamble_second);
    end

    assign i_in.ready = (r_count != 2'd2);
    assign push       = i_in.valid && i_in.ready;
    assign o_q_valid  = (r_count != 2'd0);
    assign o_q_entry  = r_slot[r_rd_ptr];

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= in_entry;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_q_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, push} - {1'b0, i_q_pop};
        end
    end

    // The back part pops only a held entry, and the count stays in range.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_pop |-> (r_count != 2'd0))
        else $error("queue popped while empty");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("queue count out of range");
    a_ptr_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0 || r_count == 2'd2) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with count");

endmodule

// File: rtl/rfd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfd_back: frame phase machine, payload buffer and result register
// Pops classified items, runs the deframing phase machine, writes and reads
// the payload buffer and presents one result per item.
// ----------------------------------------------------------------------------
module rfd_back
    import rfd_pkg::*;
#(
    parameter int BUFFER_DEPTH = DEF_BUFFER_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg_regs,
    input  logic       i_q_valid,
    input  t_entry     i_q_entry,
    output logic       o_q_pop,
    rfd_out_if.source  o_out
);

    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int CW = $clog2(BUFFER_DEPTH + 1);
    localparam int EW = (CW > INDEX_W) ? CW : INDEX_W;

    logic [BYTE_W-1:0]  r_mem [BUFFER_DEPTH];
    logic [BYTE_W-1:0]  r_mem_q;

    t_phase             r_phase,  n_phase;
    logic [BYTE_W-1:0]  r_opcode, n_opcode;
    logic [BYTE_W-1:0]  r_seq,    n_seq;
    logic [FLEN_W-1:0]  r_len,    n_len;
    logic [COUNT_W-1:0] r_cnt,    n_cnt;
    logic [BYTE_W-1:0]  r_sum,    n_sum;
    logic [BYTE_W-1:0]  r_first,  n_first;

    logic               r_out_valid;
    t_event             r_out_event;
    logic [BYTE_W-1:0]  r_out_status;
    logic [LIMIT_W-1:0] r_out_length;
    logic               r_out_rd_sel;

    t_event             ev;
    logic [BYTE_W-1:0]  status;
    logic [LIMIT_W-1:0] length;
    logic               mem_we;
    logic [BYTE_W-1:0]  b;
    logic [EW-1:0]      idx_ext;
    logic               rd_in_range;
    logic               oversize;

    assign o_q_pop     = i_q_valid && (!r_out_valid || o_out.ready);
    assign b           = i_q_entry.rx_byte;
    assign idx_ext     = EW'(i_q_entry.read_index);
    assign rd_in_range = (idx_ext < EW'(BUFFER_DEPTH));

    // Phase machine: next state and result of the popped item.
    always_comb begin
        n_phase  = r_phase;
        n_opcode = r_opcode;
        n_seq    = r_seq;
        n_len    = r_len;
        n_cnt    = r_cnt;
        n_sum    = r_sum;
        n_first  = r_first;
        ev       = EV_ABSORBED;
        status   = '0;
        length   = '0;
        mem_we   = 1'b0;
        oversize = 1'b0;
        if (o_q_pop && i_q_entry.op == OP_READ) begin
            ev = EV_READ;
        end else if (o_q_pop) begin
            unique case (r_phase)
                PH_HUNT_A: begin
                    n_phase = i_q_entry.hit_first ? PH_HUNT_B : PH_HUNT_A;
                end
                PH_HUNT_B: begin
                    n_phase = i_q_entry.hit_second ? PH_OPCODE : PH_HUNT_A;
                end
                PH_OPCODE: begin
                    n_opcode = b;
                    n_sum    = b;
                    n_phase  = PH_SEQ;
                end
                PH_SEQ: begin
                    n_seq   = b;
                    n_sum   = r_sum + b;
                    n_phase = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    n_len   = {{(FLEN_W-BYTE_W){1'b0}}, b};
                    n_sum   = r_sum + b;
                    n_phase = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    n_len    = {b, r_len[BYTE_W-1:0]};
                    n_sum    = r_sum + b;
                    n_cnt    = '0;
                    // The usable limit is the smaller of the register and the buffer.
                    oversize = (n_len > FLEN_W'(i_cfg_regs.length_limit)) ||
                               (COUNT_W'(n_len) > COUNT_W'(BUFFER_DEPTH));
                    priority if (oversize) begin
                        n_phase = PH_SKIP;
                    end else if (n_len == '0) begin
                        n_phase = PH_CHECK;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    mem_we = (r_cnt < COUNT_W'(BUFFER_DEPTH));
                    if (r_cnt == '0) begin
                        n_first = b;
                    end
                    n_sum = r_sum + b;
                    n_cnt = r_cnt + 1'b1;
                    if (n_cnt >= {1'b0, r_len}) begin
                        n_phase = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    n_phase = PH_HUNT_A;
                    priority if (b != r_sum) begin
                        ev = EV_BAD_SUM;
                    end else if (r_opcode != i_cfg_regs.wanted_opcode ||
                                 r_seq != i_cfg_regs.wanted_sequence) begin
                        ev = EV_NOT_OURS;
                    end else begin
                        ev     = EV_ACCEPTED;
                        length = r_len[LIMIT_W-1:0];
                        status = (r_len == '0) ? i_cfg_regs.empty_status : r_first;
                    end
                end
                PH_SKIP: begin
                    n_cnt = r_cnt + 1'b1;
                    if (n_cnt >= ({1'b0, r_len} + 1'b1)) begin
                        ev      = EV_OVERSIZE;
                        n_phase = PH_HUNT_A;
                    end
                end
                default: begin
                    n_phase = i_q_entry.hit_first ? PH_HUNT_B : PH_HUNT_A;
                end
            endcase
        end
    end

    // Payload buffer: one write or one registered read per item.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_cnt[AW-1:0]] <= b;
        end
        if (o_q_pop && i_q_entry.op == OP_READ && rd_in_range) begin
            r_mem_q <= r_mem[idx_ext[AW-1:0]];
        end
    end

    // Frame state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT_A;
            r_cnt   <= '0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_opcode <= n_opcode;
        r_seq    <= n_seq;
        r_len    <= n_len;
        r_sum    <= n_sum;
        r_first  <= n_first;
    end

    // Result register, held while the sink stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_out_event  <= ev;
            r_out_status <= status;
            r_out_length <= length;
            r_out_rd_sel <= (i_q_entry.op == OP_READ) && rd_in_range;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.event_res    = r_out_event;
    assign o_out.reply_status = r_out_status;
    assign o_out.reply_length = r_out_length;
    assign o_out.read_data    = r_out_rd_sel ? r_mem_q : '0;

    // The phase stays one-hot, buffer writes come only from payload bytes,
    // and only an accepted frame reports a length.
    a_phase_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_phase))
        else $error("frame phase not one-hot");
    a_write_in_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_phase == PH_PAYLOAD && i_q_entry.op == OP_RX))
        else $error("buffer written outside payload phase");
    a_length_only_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_event != EV_ACCEPTED) |-> (r_out_length == '0))
        else $error("length reported for a frame that was not accepted");

endmodule

// File: rtl/reply_frame_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reply_frame_deframer: serial reply frame extractor with additive checksum
// Path: an accepted item is first held in the queue, and its result is then
//   registered in the result register and presented from there.
// Throughput: one item per cycle while the sink does not stall the result,
//   set by the single-step phase machine and the one buffer port used once per item.
// Reset: synchronous, active low; registers return to defaults, the machine
//   hunts for the first preamble, and the buffer is left as it is.
// ----------------------------------------------------------------------------
module reply_frame_deframer
    import rfd_pkg::*;
#(
    parameter int BUFFER_DEPTH = DEF_BUFFER_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rfd_in_if.sink     i_in,
    rfd_out_if.source  o_out,
    rfd_cfg_if.sink    i_cfg
);

    t_cfg   r_cfg;
    logic   q_valid;
    t_entry q_entry;
    logic   q_pop;

    // Configuration registers; writes to unknown indexes are dropped.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.preamble_first  <= '0;
            r_cfg.preamble_second <= '0;
            r_cfg.wanted_opcode   <= '0;
            r_cfg.wanted_sequence <= RST_WANTED_SEQUENCE;
            r_cfg.length_limit    <= RST_LENGTH_LIMIT;
            r_cfg.empty_status    <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_PREAMBLE_FIRST:  r_cfg.preamble_first  <= i_cfg.data[BYTE_W-1:0];
                CFG_PREAMBLE_SECOND: r_cfg.preamble_second <= i_cfg.data[BYTE_W-1:0];
                CFG_WANTED_OPCODE:   r_cfg.wanted_opcode   <= i_cfg.data[BYTE_W-1:0];
                CFG_WANTED_SEQUENCE: r_cfg.wanted_sequence <= i_cfg.data[BYTE_W-1:0];
                CFG_LENGTH_LIMIT:    r_cfg.length_limit    <= i_cfg.data[LIMIT_W-1:0];
                CFG_EMPTY_STATUS:    r_cfg.empty_status    <= i_cfg.data[BYTE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Intake and classification.
    rfd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_regs (r_cfg),
        .i_in       (i_in),
        .o_q_valid  (q_valid),
        .o_q_entry  (q_entry),
        .i_q_pop    (q_pop)
    );

    // Phase machine, buffer and results.
    rfd_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_regs (r_cfg),
        .i_q_valid  (q_valid),
        .i_q_entry  (q_entry),
        .o_q_pop    (q_pop),
        .o_out      (o_out)
    );

endmodule
